### design/lrccf_pkg.sv
// Shared types, codes and constants of the LRC command frame codec.
package lrccf_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0]  START_BYTE    = 8'h55;
  localparam logic [15:0] MAX_LEN_RESET = 16'd999;

  // input item kind
  localparam logic IN_CMD = 1'b0;
  localparam logic IN_RSP = 1'b1;

  // result kind
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // end status
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CKS = 2'd1;
  localparam logic [1:0] ST_LEN = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] status_word;
    logic [15:0] response_length;
    logic        end_of_run;
  } out_item_t;

  // Work descriptor from the front end to the emitter.
  typedef struct packed {
    logic        is_rx;
    logic        tx_start;    // send start byte first
    logic        tx_last;     // send checksum after the byte
    logic [7:0]  byte_val;
    logic [7:0]  tx_cks;
    logic        rx_end;      // end status rather than data byte
    logic [1:0]  status;
    logic [15:0] status_word;
    logic [15:0] response_length;
  } cmd_t;

endpackage

### design/lrccf_front.sv
// Front end: accepts items, tracks framing and header state, issues descriptors.
module lrccf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrccf_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               q_full,
  output logic               q_push,
  output lrccf_pkg::cmd_t    q_data
);
  import lrccf_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_CHECK  = 2'd2;

  logic [15:0] max_len;
  logic        tx_in_frame, tx_in_frame_next;
  logic [7:0]  tx_checksum, tx_checksum_next;
  logic [1:0]  rx_phase, rx_phase_next;
  logic [1:0]  rx_header_count, rx_header_count_next;
  logic [15:0] rx_status_word, rx_status_word_next;
  logic [15:0] rx_length, rx_length_next;
  logic [15:0] rx_remaining, rx_remaining_next;
  logic [7:0]  rx_checksum, rx_checksum_next;

  logic        accept;
  logic        has_result;
  logic [7:0]  b;
  logic [7:0]  tx_cks_acc;
  logic [7:0]  hdr_cks;
  logic [15:0] new_len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_item.data_byte;
  assign q_push   = accept && has_result;

  always_comb begin
    tx_in_frame_next     = tx_in_frame;
    tx_checksum_next     = tx_checksum;
    rx_phase_next        = rx_phase;
    rx_header_count_next = rx_header_count;
    rx_status_word_next  = rx_status_word;
    rx_length_next       = rx_length;
    rx_remaining_next    = rx_remaining;
    rx_checksum_next     = rx_checksum;
    has_result           = 1'b0;
    q_data               = '0;
    tx_cks_acc           = (tx_in_frame ? tx_checksum : 8'd0) ^ b;
    hdr_cks              = ((rx_header_count == 2'd0) ? 8'd0 : rx_checksum) ^ b;
    new_len              = {rx_length[15:8], b};

    if (in_item.kind == IN_CMD) begin
      has_result       = 1'b1;
      q_data.tx_start  = !tx_in_frame;
      q_data.tx_last   = in_item.frame_last;
      q_data.byte_val  = b;
      q_data.tx_cks    = ~tx_cks_acc;
      if (in_item.frame_last) begin
        tx_in_frame_next = 1'b0;
        tx_checksum_next = 8'd0;
      end else begin
        tx_in_frame_next = 1'b1;
        tx_checksum_next = tx_cks_acc;
      end
    end else begin
      q_data.is_rx           = 1'b1;
      q_data.byte_val        = b;
      q_data.status_word     = rx_status_word;
      q_data.response_length = rx_length;
      case (rx_phase)
        PH_DATA: begin
          has_result        = 1'b1;
          rx_checksum_next  = rx_checksum ^ b;
          rx_remaining_next = rx_remaining - 16'd1;
          if (rx_remaining == 16'd1) begin
            rx_phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          has_result           = 1'b1;
          q_data.rx_end        = 1'b1;
          q_data.status        = (b == ~rx_checksum) ? ST_OK : ST_CKS;
          rx_phase_next        = PH_HEADER;
          rx_header_count_next = 2'd0;
          rx_checksum_next     = 8'd0;
        end
        default: begin
          rx_checksum_next = hdr_cks;
          case (rx_header_count)
            2'd0: rx_status_word_next = {b, 8'd0};
            2'd1: rx_status_word_next = {rx_status_word[15:8], b};
            2'd2: rx_length_next      = {b, 8'd0};
            default: rx_length_next   = new_len;
          endcase
          if (rx_header_count != 2'd3) begin
            rx_header_count_next = rx_header_count + 2'd1;
            rx_phase_next        = PH_HEADER;
          end else begin
            rx_header_count_next = 2'd0;
            if (new_len > max_len) begin
              // length error: report at once, back to header
              has_result             = 1'b1;
              q_data.rx_end          = 1'b1;
              q_data.status          = ST_LEN;
              q_data.byte_val        = 8'd0;
              q_data.response_length = new_len;
              rx_phase_next          = PH_HEADER;
              rx_checksum_next       = 8'd0;
            end else if (new_len == 16'd0) begin
              rx_phase_next = PH_CHECK;
            end else begin
              rx_remaining_next = new_len;
              rx_phase_next     = PH_DATA;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len         <= MAX_LEN_RESET;
      tx_in_frame     <= 1'b0;
      tx_checksum     <= 8'd0;
      rx_phase        <= PH_HEADER;
      rx_header_count <= 2'd0;
      rx_status_word  <= 16'd0;
      rx_length       <= 16'd0;
      rx_remaining    <= 16'd0;
      rx_checksum     <= 8'd0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (accept) begin
        tx_in_frame     <= tx_in_frame_next;
        tx_checksum     <= tx_checksum_next;
        rx_phase        <= rx_phase_next;
        rx_header_count <= rx_header_count_next;
        rx_status_word  <= rx_status_word_next;
        rx_length       <= rx_length_next;
        rx_remaining    <= rx_remaining_next;
        rx_checksum     <= rx_checksum_next;
      end
    end
  end

endmodule

### design/lrccf_queue.sv
// Small descriptor FIFO between the front end and the emitter.
module lrccf_queue #(
  parameter int Depth = lrccf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrccf_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lrccf_pkg::cmd_t head_data
);
  import lrccf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

### design/lrccf_emit.sv
// Emitter: expands descriptors into result transfers through an output register.
module lrccf_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  lrccf_pkg::cmd_t     head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lrccf_pkg::out_item_t out_item
);
  import lrccf_pkg::*;

  // sub-result of a transmit descriptor
  localparam logic [1:0] SUB_START = 2'd0;
  localparam logic [1:0] SUB_BYTE  = 2'd1;
  localparam logic [1:0] SUB_CKS   = 2'd2;

  logic [1:0] sub;
  logic [1:0] sub_eff;
  logic       load;
  logic       final_sub;
  out_item_t  res;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && final_sub;

  always_comb begin
    sub_eff   = (sub == SUB_START && !head_data.tx_start) ? SUB_BYTE : sub;
    final_sub = head_data.is_rx ||
                (sub_eff == SUB_CKS) ||
                (sub_eff == SUB_BYTE && !head_data.tx_last);
    res            = '0;
    res.end_of_run = final_sub;
    if (head_data.is_rx) begin
      res.out_kind        = head_data.rx_end ? KIND_END : KIND_DATA;
      res.out_byte        = head_data.byte_val;
      res.status          = head_data.status;
      res.status_word     = head_data.status_word;
      res.response_length = head_data.response_length;
    end else begin
      res.out_kind = KIND_TX;
      case (sub_eff)
        SUB_START: res.out_byte = START_BYTE;
        SUB_BYTE:  res.out_byte = head_data.byte_val;
        default:   res.out_byte = head_data.tx_cks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= SUB_START;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        sub <= final_sub ? SUB_START : sub_eff + 2'd1;
      end
    end
  end

endmodule

### design/lrc_command_frame_codec.sv
// Top level of the LRC command frame codec.
// Takes one item per cycle while the queue is not full. Command bytes (kind 0) come
// out wrapped in a frame: start byte 0x55 ahead of the first byte, inverted XOR of
// the payload after the byte marked last. Response bytes (kind 1) are parsed as a
// 4-byte header (status word, length, high byte first), length data bytes passed on,
// then a checksum byte that yields an end status (ok or checksum mismatch). A length
// that exceeds the limit written through cfg_we/cfg_wdata, reset 999, instead ends
// the response at the last header byte with a length error. Other header bytes give
// no result. The front end updates state in the cycle an item transfers and queues a
// descriptor; the emitter drives one result per cycle from its output register while
// out_ready is high, so a frame-opening or frame-closing command byte yields two
// or three results, which the QueueDepth queue absorbs while input keeps flowing.
module lrc_command_frame_codec #(
  parameter int QueueDepth = lrccf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lrccf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lrccf_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import lrccf_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  lrccf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  lrccf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  lrccf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_valid),
    .head_data (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
